### src/exposure_bracket_sequencer_macros.svh
// assertion macros used by the exposure bracket sequencer checker
`ifndef EXPOSURE_BRACKET_SEQUENCER_MACROS_SVH
`define EXPOSURE_BRACKET_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define EBS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("exposure bracket sequencer assertion failed");

// next-cycle implication, disabled while in reset
`define EBS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("exposure bracket sequencer assertion failed");

`endif

### src/ebs_pkg.sv
// shared types, codes and constants of the exposure bracket sequencer
package ebs_pkg;

  localparam int TICK_W = 7;
  localparam int EXPO_W = 8;
  localparam int CODE_W = 8;
  localparam int STEP_W = 7;
  localparam int CFG_ADDR_W = 3;

  // ack wait timeout and settle length, in ticks
  localparam logic [TICK_W-1:0] ACK_TIMEOUT_TICKS = 7'd100;
  localparam logic [TICK_W-1:0] SETTLE_TICKS = 7'd50;

  // default depth of the result queue
  localparam int OQ_DEPTH_DEF = 4;

  // input kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_EXEC = 2'd2;
  localparam logic [1:0] KIND_NODE = 2'd3;

  // result types
  localparam logic [1:0] TYPE_STATUS = 2'd0;
  localparam logic [1:0] TYPE_EXPO = 2'd1;
  localparam logic [1:0] TYPE_TRIG = 2'd2;

  // value sent with an image trigger
  localparam logic [CODE_W-1:0] TRIG_CODE = 8'd1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_NODE_ACK = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_END = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CFG_DONE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_EXPO_MIN = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_EXPO_MAX = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_EXPO_STEP = 3'd6;

  typedef struct packed {
    logic [CODE_W-1:0]        node_ack_code;
    logic [CODE_W-1:0]        start_code;
    logic [CODE_W-1:0]        end_code;
    logic [CODE_W-1:0]        config_done_code;
    logic signed [EXPO_W-1:0] exposure_min;
    logic signed [EXPO_W-1:0] exposure_max;
    logic [STEP_W-1:0]        exposure_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    node_ack_code:    8'd3,
    start_code:       8'd10,
    end_code:         8'd11,
    config_done_code: 8'd12,
    exposure_min:     -8'sd32,
    exposure_max:     8'sd32,
    exposure_step:    7'd16
  };

  typedef struct packed {
    logic [1:0]               out_type;
    logic [CODE_W-1:0]        out_code;
    logic signed [EXPO_W-1:0] exposure_value;
    logic                     last;
  } res_t;

  // results produced by one accepted transaction
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

### src/ebs_regs.sv
// configuration register file of the exposure bracket sequencer
module ebs_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ebs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ebs_pkg::CODE_W-1:0]     cfg_wdata,
  output ebs_pkg::cfg_t                  cfg
);
  import ebs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_NODE_ACK:  cfg_nxt.node_ack_code = cfg_wdata;
        REG_START:     cfg_nxt.start_code = cfg_wdata;
        REG_END:       cfg_nxt.end_code = cfg_wdata;
        REG_CFG_DONE:  cfg_nxt.config_done_code = cfg_wdata;
        REG_EXPO_MIN:  cfg_nxt.exposure_min = cfg_wdata;
        REG_EXPO_MAX:  cfg_nxt.exposure_max = cfg_wdata;
        REG_EXPO_STEP: cfg_nxt.exposure_step = cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/ebs_core.sv
// sequencing state machine: message flags, ack waits, settle and exposure sweep
module ebs_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [1:0]                 kind,
  input  logic [ebs_pkg::CODE_W-1:0] msg_code,
  input  ebs_pkg::cfg_t              cfg,
  output ebs_pkg::push_t             push
);
  import ebs_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WAIT_CFG = 3'd1;
  localparam logic [2:0] PH_SETTLE = 3'd2;
  localparam logic [2:0] PH_WAIT_TRIG = 3'd3;

  logic [2:0]          phase_r, phase_nxt;
  logic signed [8:0]   expo_now_r, expo_now_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic                first_r, first_nxt;
  logic                start_r, start_nxt;
  logic                cfg_ack_r, cfg_ack_nxt;
  logic                trig_ack_r, trig_ack_nxt;

  logic signed [8:0]   min9;
  logic signed [8:0]   max9;
  logic signed [8:0]   sweep_expo;
  logic                sweep_ok;
  logic [TICK_W-1:0]   tick_inc;
  logic                timed_out;
  res_t                sweep_res;
  res_t                expo_res;
  res_t                trig_res;
  res_t                start_res;

  // sweep arithmetic: candidate exposure and range check
  assign min9 = {cfg.exposure_min[EXPO_W-1], cfg.exposure_min};
  assign max9 = {cfg.exposure_max[EXPO_W-1], cfg.exposure_max};
  assign sweep_expo = (phase_r == PH_IDLE) ? min9
                    : expo_now_r + $signed({2'b00, cfg.exposure_step});
  assign sweep_ok = (sweep_expo <= max9);
  assign tick_inc = tick_r + 1'b1;
  assign timed_out = (tick_r >= ACK_TIMEOUT_TICKS);

  // result templates
  always_comb begin
    sweep_res = '0;
    sweep_res.last = 1'b1;
    if (sweep_ok) begin
      sweep_res.out_type = TYPE_EXPO;
      sweep_res.exposure_value = sweep_expo[EXPO_W-1:0];
    end else begin
      sweep_res.out_type = TYPE_STATUS;
      sweep_res.out_code = cfg.end_code;
    end
    expo_res = '0;
    expo_res.out_type = TYPE_EXPO;
    expo_res.exposure_value = expo_now_r[EXPO_W-1:0];
    expo_res.last = 1'b1;
    trig_res = '0;
    trig_res.out_type = TYPE_TRIG;
    trig_res.out_code = TRIG_CODE;
    trig_res.last = 1'b1;
    start_res = '0;
    start_res.out_type = TYPE_STATUS;
    start_res.out_code = cfg.start_code;
  end

  // next state and results of one transaction
  always_comb begin
    phase_nxt = phase_r;
    expo_now_nxt = expo_now_r;
    tick_nxt = tick_r;
    first_nxt = first_r;
    start_nxt = start_r;
    cfg_ack_nxt = cfg_ack_r;
    trig_ack_nxt = trig_ack_r;
    push = '0;
    if (in_fire) begin
      unique case (kind)
        KIND_START: begin
          if (msg_code == cfg.start_code) start_nxt = 1'b1;
        end
        KIND_EXEC: begin
          if (msg_code == cfg.node_ack_code || msg_code == cfg.start_code) begin
            trig_ack_nxt = 1'b1;
          end
        end
        KIND_NODE: begin
          if (msg_code == cfg.config_done_code) cfg_ack_nxt = 1'b1;
        end
        default: begin
          // tick: advance the sequence
          unique case (phase_r)
            PH_IDLE: begin
              if (start_r) begin
                start_nxt = 1'b0;
                first_nxt = 1'b1;
                push.cnt = 2'd2;
                push.res0 = start_res;
                push.res1 = sweep_res;
                expo_now_nxt = min9;
                if (sweep_ok) begin
                  cfg_ack_nxt = 1'b0;
                  tick_nxt = '0;
                  phase_nxt = PH_WAIT_CFG;
                end
              end
            end
            PH_WAIT_CFG: begin
              if (cfg_ack_r) begin
                tick_nxt = '0;
                phase_nxt = PH_SETTLE;
              end else if (timed_out) begin
                push.cnt = 2'd1;
                push.res0 = expo_res;
                tick_nxt = 7'd1;
              end else begin
                tick_nxt = tick_inc;
              end
            end
            PH_SETTLE: begin
              if (tick_inc >= SETTLE_TICKS) begin
                tick_nxt = '0;
                if (first_r) begin
                  first_nxt = 1'b0;
                end else begin
                  push.cnt = 2'd1;
                  push.res0 = trig_res;
                  trig_ack_nxt = 1'b0;
                  phase_nxt = PH_WAIT_TRIG;
                end
              end else begin
                tick_nxt = tick_inc;
              end
            end
            PH_WAIT_TRIG: begin
              if (trig_ack_r) begin
                push.cnt = 2'd1;
                push.res0 = sweep_res;
                if (sweep_ok) begin
                  expo_now_nxt = sweep_expo;
                  cfg_ack_nxt = 1'b0;
                  tick_nxt = '0;
                  phase_nxt = PH_WAIT_CFG;
                end else begin
                  expo_now_nxt = min9;
                  phase_nxt = PH_IDLE;
                end
              end else if (timed_out) begin
                push.cnt = 2'd1;
                push.res0 = trig_res;
                tick_nxt = 7'd1;
              end else begin
                tick_nxt = tick_inc;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      expo_now_r <= {CFG_RESET.exposure_min[EXPO_W-1], CFG_RESET.exposure_min};
      tick_r <= '0;
      first_r <= 1'b0;
      start_r <= 1'b0;
      cfg_ack_r <= 1'b0;
      trig_ack_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      expo_now_r <= expo_now_nxt;
      tick_r <= tick_nxt;
      first_r <= first_nxt;
      start_r <= start_nxt;
      cfg_ack_r <= cfg_ack_nxt;
      trig_ack_r <= trig_ack_nxt;
    end
  end

endmodule

### src/ebs_outq.sv
// result queue: takes up to two results per cycle, hands out one per transaction
module ebs_outq #(
  parameter int DEPTH = ebs_pkg::OQ_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ebs_pkg::push_t push,
  output logic           space_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output ebs_pkg::res_t  out_res
);
  import ebs_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ACC_LIM = CW'(DEPTH - 2);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  res_t          mem [DEPTH];
  logic [IW-1:0] wr_r, wr_nxt;
  logic [IW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] wr_p1;
  logic          pop;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // pointer and fill bookkeeping
  assign wr_p1 = ptr_inc(wr_r);
  assign pop = out_valid && out_ready;
  assign space_ok = (cnt_r <= ACC_LIM);
  assign out_valid = (cnt_r != '0);
  assign out_res = mem[rd_r];

  always_comb begin
    case (push.cnt)
      2'd1: wr_nxt = wr_p1;
      2'd2: wr_nxt = ptr_inc(wr_p1);
      default: wr_nxt = wr_r;
    endcase
    rd_nxt = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.cnt) - CW'(pop);
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_r] <= push.res0;
    if (push.cnt == 2'd2) mem[wr_p1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### src/exposure_bracket_sequencer.sv
// top level of the exposure bracket sequencer
// Takes one input transaction per clock whenever the result queue has room for
// two more results; each transaction is handled in the cycle it is accepted by
// the sequencing state machine, and its results (none, one, or two for a start
// tick) are written to the result queue and appear on the output no earlier
// than the next cycle, one per output transaction. Only the depth of that
// queue, and so how long the consumer stalls, limits the rate. There is no
// clearing pass after reset. Configuration writes take effect on the next clock.
module exposure_bracket_sequencer #(
  parameter int OQ_DEPTH = ebs_pkg::OQ_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // msg_code[7:0]
  input  logic [1:0]                     in_tuser,   // kind[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // out_code[7:0], exposure_value[15:8]
  output logic [1:0]                     out_tuser,  // out_type[1:0]
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [ebs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]                     cfg_wdata
);
  import ebs_pkg::*;

  cfg_t  cfg;
  push_t push;
  res_t  head;
  logic  in_fire;

  assign in_fire = in_tvalid && in_tready;

  ebs_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ebs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .kind     (in_tuser),
    .msg_code (in_tdata),
    .cfg      (cfg),
    .push     (push)
  );

  ebs_outq #(
    .DEPTH (OQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  // output packing
  assign out_tdata = {head.exposure_value, head.out_code};
  assign out_tuser = head.out_type;
  assign out_tlast = head.last;

endmodule

### src/ebs_checker.sv
// port-level checker of the exposure bracket sequencer and its bind
`include "exposure_bracket_sequencer_macros.svh"

module ebs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import ebs_pkg::*;

  // only the three result types are ever produced
  `EBS_ASSERT_NOW(a_type_known, clk, rst_n, out_tvalid, out_tuser != 2'd3)

  // an exposure setting carries a zero code
  `EBS_ASSERT_NOW(a_expo_code_zero, clk, rst_n,
    out_tvalid && out_tuser == TYPE_EXPO, out_tdata[7:0] == 8'd0)

  // status and trigger results carry a zero exposure
  `EBS_ASSERT_NOW(a_other_expo_zero, clk, rst_n,
    out_tvalid && out_tuser != TYPE_EXPO, out_tdata[15:8] == 8'd0)

  // a trigger is always alone and carries value one
  `EBS_ASSERT_NOW(a_trig_single, clk, rst_n,
    out_tvalid && out_tuser == TYPE_TRIG, out_tlast && out_tdata[7:0] == TRIG_CODE)

  // a stalled transaction holds
  `EBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind exposure_bracket_sequencer ebs_checker u_ebs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
